>>> hw/rtl/i2ctbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C two-byte read sequencer package
// Shared types and constants: event kinds, transaction phases, register
// indexes, configuration set and the payload structures of both channels.
// ----------------------------------------------------------------------------
package i2ctbr_pkg;

    localparam int unsigned KIND_W     = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned EVENT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [KIND_W-1:0] {
        EV_START = 3'd0,
        EV_ACK   = 3'd1,
        EV_NACK  = 3'd2,
        EV_RX    = 3'd3,
        EV_MSTOP = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_SEND_CMD  = 3'd1,
        PH_WAIT_RESP = 3'd2,
        PH_RECV_HI   = 3'd3,
        PH_RECV_LO   = 3'd4,
        PH_END       = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS  = 3'd0,
        CFG_COMMAND_BYTE    = 3'd1,
        CFG_READ_BIT        = 3'd2,
        CFG_WRITE_BIT       = 3'd3,
        CFG_DONE_EVENT_CODE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0]  device_address;
        logic [BYTE_W-1:0]  command_byte;
        logic               read_bit;
        logic               write_bit;
        logic [EVENT_W-1:0] done_event_code;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic               clear_tx;
        logic               send_start;
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               send_ack;
        logic               send_nack;
        logic               send_stop;
        logic               fault;
        logic               done_res;
        logic [WORD_W-1:0]  word_out;
        logic [EVENT_W-1:0] done_event;
        logic               busy_out;
    } t_out;

    // Address byte on the bus: seven-bit address followed by the direction bit.
    function automatic logic [BYTE_W-1:0] addr_byte(input logic [ADDR_W-1:0] addr,
                                                    input logic dir);
        return {addr, dir};
    endfunction

endpackage

>>> hw/rtl/i2c_two_byte_read_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C two-byte read sequencer
// Sequences a command byte write followed by a 16-bit big-endian read.
// ----------------------------------------------------------------------------
// Usage:
// Each bus event (start, ack, nack, received byte, master stop) is sent as one
// transfer on the input channel (i_in_valid / o_in_stall). For every event the
// block returns exactly one result on the output channel (o_out_valid /
// i_out_stall) carrying the bus commands to issue, the fault flag, the
// assembled word and the busy flag after the event.
// The result is registered: it enters the output register on the edge that
// accepts the event. One event is accepted every cycle unless the input is
// stalled; phase, busy and word update in the same cycle they are read.
// When the receiver stalls, the output register holds its result and the
// input channel is stalled only while that register is full and stalled.
// Configuration registers are written through i_cfg_valid / o_cfg_ready,
// which is always ready; write them only while no event is in flight.
// Reset (synchronous, active low) returns the block to the start phase, not
// busy, with a cleared word and the configuration at its reset values.
// ----------------------------------------------------------------------------
module i2c_two_byte_read_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  i2ctbr_pkg::t_in                     i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output i2ctbr_pkg::t_out                    o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2ctbr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2ctbr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import i2ctbr_pkg::*;

    t_cfg                cfg;
    logic                in_fire;

    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_busy;
    logic                n_busy;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   n_word;

    t_out                r_out;
    t_out                n_out;
    logic                r_out_valid;

    i2ctbr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_busy  = r_busy;
        n_word  = r_word;
        if (i_in_data.kind == EV_START) begin
            // A start always restarts the transaction; the word is kept.
            n_phase = PH_START;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            unique case (i_in_data.kind)
                EV_ACK: begin
                    unique case (r_phase)
                        PH_START:     n_phase = PH_SEND_CMD;
                        PH_SEND_CMD:  n_phase = PH_WAIT_RESP;
                        PH_WAIT_RESP: n_phase = PH_RECV_HI;
                        default: ;
                    endcase
                end
                EV_RX: begin
                    unique case (r_phase)
                        PH_RECV_HI: begin
                            n_word  = {i_in_data.rx_byte, {BYTE_W{1'b0}}};
                            n_phase = PH_RECV_LO;
                        end
                        PH_RECV_LO: begin
                            n_word  = {r_word[WORD_W-1:BYTE_W], i_in_data.rx_byte};
                            n_phase = PH_END;
                        end
                        default: ;
                    endcase
                end
                EV_MSTOP: begin
                    if (r_phase == PH_END) begin
                        n_phase = PH_START;
                        n_busy  = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Bus commands and result fields.
    always_comb begin
        n_out          = '0;
        n_out.word_out = n_word;
        n_out.busy_out = n_busy;
        if (i_in_data.kind == EV_START) begin
            n_out.send_start = 1'b1;
            n_out.tx_valid   = 1'b1;
            n_out.tx_byte    = addr_byte(cfg.device_address, cfg.write_bit);
        end else if (!r_busy) begin
            n_out.fault = 1'b1;
        end else begin
            unique case (i_in_data.kind)
                EV_ACK: begin
                    unique case (r_phase)
                        PH_START: begin
                            n_out.clear_tx = 1'b1;
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = cfg.command_byte;
                        end
                        PH_SEND_CMD: begin
                            n_out.clear_tx   = 1'b1;
                            n_out.send_start = 1'b1;
                            n_out.tx_valid   = 1'b1;
                            n_out.tx_byte    = addr_byte(cfg.device_address, cfg.read_bit);
                        end
                        PH_WAIT_RESP: n_out.clear_tx = 1'b1;
                        // An ack while waiting for the high byte is harmless.
                        PH_RECV_HI: ;
                        default: n_out.fault = 1'b1;
                    endcase
                end
                EV_NACK: begin
                    if (r_phase == PH_WAIT_RESP) begin
                        // The device did not answer the read; repeat the
                        // repeated start with the read address.
                        n_out.send_start = 1'b1;
                        n_out.tx_valid   = 1'b1;
                        n_out.tx_byte    = addr_byte(cfg.device_address, cfg.read_bit);
                    end else begin
                        n_out.fault = 1'b1;
                    end
                end
                EV_RX: begin
                    unique case (r_phase)
                        PH_RECV_HI: n_out.send_ack = 1'b1;
                        PH_RECV_LO: begin
                            n_out.send_nack = 1'b1;
                            n_out.send_stop = 1'b1;
                        end
                        default: n_out.fault = 1'b1;
                    endcase
                end
                EV_MSTOP: begin
                    if (r_phase == PH_END) begin
                        n_out.done_res   = 1'b1;
                        n_out.done_event = cfg.done_event_code;
                    end else begin
                        n_out.fault = 1'b1;
                    end
                end
                default: n_out.fault = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_busy      <= 1'b0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_busy  <= n_busy;
                r_word  <= n_word;
            end
            if (!o_in_stall) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/i2ctbr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C two-byte read sequencer configuration registers
// Holds the device address, command byte, direction bits and completion
// event code, written one at a time through the configuration channel.
// ----------------------------------------------------------------------------
module i2ctbr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2ctbr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2ctbr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output i2ctbr_pkg::t_cfg                    o_cfg
);
    import i2ctbr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            // Indexes past the last register are accepted and ignored.
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS:  n_cfg.device_address  = i_cfg_data[ADDR_W-1:0];
                CFG_COMMAND_BYTE:    n_cfg.command_byte    = i_cfg_data[BYTE_W-1:0];
                CFG_READ_BIT:        n_cfg.read_bit        = i_cfg_data[0];
                CFG_WRITE_BIT:       n_cfg.write_bit       = i_cfg_data[0];
                CFG_DONE_EVENT_CODE: n_cfg.done_event_code = i_cfg_data[EVENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address  <= '0;
            r_cfg.command_byte    <= '0;
            r_cfg.read_bit        <= 1'b1;
            r_cfg.write_bit       <= 1'b0;
            r_cfg.done_event_code <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> bench/sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C two-byte read sequencer checker
// Watches the event, result and configuration channels of the sequencer,
// keeps its own copy of the phase, busy flag, word and register set, and
// compares every result transfer with the oldest expected bus command set.
// ----------------------------------------------------------------------------
module sequencer_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  i2ctbr_pkg::t_in                     i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  i2ctbr_pkg::t_out                    i_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [i2ctbr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2ctbr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import i2ctbr_pkg::*;

    localparam int MAX_REPORTS = 10;

    t_cfg              regs;
    t_phase            seq_phase;
    logic              seq_busy;
    logic [WORD_W-1:0] seq_word;
    t_out              expected_commands[$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [BYTE_W-1:0] bus_address(input logic dir);
        return {regs.device_address, dir};
    endfunction

    // Advances the sequencer copy by one event and returns the commands it issues.
    function automatic t_out next_bus_commands(input t_in ev);
        t_out r;
        r = '0;
        if (ev.kind == EV_START) begin
            // A start is honoured in any phase; the word is deliberately kept.
            seq_busy     = 1'b1;
            seq_phase    = PH_START;
            r.send_start = 1'b1;
            r.tx_valid   = 1'b1;
            r.tx_byte    = bus_address(regs.write_bit);
        end else if (!seq_busy || ev.kind > EV_MSTOP) begin
            r.fault = 1'b1;
        end else begin
            case (ev.kind)
                EV_ACK: begin
                    case (seq_phase)
                        PH_START: begin
                            r.clear_tx = 1'b1;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = regs.command_byte;
                            seq_phase  = PH_SEND_CMD;
                        end
                        PH_SEND_CMD: begin
                            r.clear_tx   = 1'b1;
                            r.send_start = 1'b1;
                            r.tx_valid   = 1'b1;
                            r.tx_byte    = bus_address(regs.read_bit);
                            seq_phase    = PH_WAIT_RESP;
                        end
                        PH_WAIT_RESP: begin
                            r.clear_tx = 1'b1;
                            seq_phase  = PH_RECV_HI;
                        end
                        PH_RECV_HI: ;
                        default: r.fault = 1'b1;
                    endcase
                end
                EV_NACK: begin
                    if (seq_phase == PH_WAIT_RESP) begin
                        r.send_start = 1'b1;
                        r.tx_valid   = 1'b1;
                        r.tx_byte    = bus_address(regs.read_bit);
                    end else begin
                        r.fault = 1'b1;
                    end
                end
                EV_RX: begin
                    if (seq_phase == PH_RECV_HI) begin
                        seq_word   = {ev.rx_byte, 8'h00};
                        r.send_ack = 1'b1;
                        seq_phase  = PH_RECV_LO;
                    end else if (seq_phase == PH_RECV_LO) begin
                        seq_word    = seq_word | {8'h00, ev.rx_byte};
                        r.send_nack = 1'b1;
                        r.send_stop = 1'b1;
                        seq_phase   = PH_END;
                    end else begin
                        r.fault = 1'b1;
                    end
                end
                default: begin
                    if (seq_phase == PH_END) begin
                        seq_phase  = PH_START;
                        seq_busy   = 1'b0;
                        r.done_res = 1'b1;
                    end else begin
                        r.fault = 1'b1;
                    end
                end
            endcase
        end
        r.word_out   = seq_word;
        r.done_event = r.done_res ? regs.done_event_code : '0;
        r.busy_out   = seq_busy;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [EVENT_W-1:0] want,
                               input logic [EVENT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            regs      = '{device_address: '0, command_byte: '0, read_bit: 1'b1,
                          write_bit: 1'b0, done_event_code: '0};
            seq_phase = PH_START;
            seq_busy  = 1'b0;
            seq_word  = '0;
            expected_commands.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_commands.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result transfer with nothing expected, got %h",
                                 $realtime, i_out_data);
                    end
                end else begin
                    want = expected_commands.pop_front();
                    check_field("clear_tx",   EVENT_W'(want.clear_tx),
                                EVENT_W'(i_out_data.clear_tx));
                    check_field("send_start", EVENT_W'(want.send_start),
                                EVENT_W'(i_out_data.send_start));
                    check_field("tx_valid",   EVENT_W'(want.tx_valid),
                                EVENT_W'(i_out_data.tx_valid));
                    check_field("tx_byte",    EVENT_W'(want.tx_byte),
                                EVENT_W'(i_out_data.tx_byte));
                    check_field("send_ack",   EVENT_W'(want.send_ack),
                                EVENT_W'(i_out_data.send_ack));
                    check_field("send_nack",  EVENT_W'(want.send_nack),
                                EVENT_W'(i_out_data.send_nack));
                    check_field("send_stop",  EVENT_W'(want.send_stop),
                                EVENT_W'(i_out_data.send_stop));
                    check_field("fault",      EVENT_W'(want.fault),
                                EVENT_W'(i_out_data.fault));
                    check_field("done_res",   EVENT_W'(want.done_res),
                                EVENT_W'(i_out_data.done_res));
                    check_field("word_out",   EVENT_W'(want.word_out),
                                EVENT_W'(i_out_data.word_out));
                    check_field("done_event", want.done_event, i_out_data.done_event);
                    check_field("busy_out",   EVENT_W'(want.busy_out),
                                EVENT_W'(i_out_data.busy_out));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEVICE_ADDRESS:  regs.device_address  = i_cfg_data[ADDR_W-1:0];
                    CFG_COMMAND_BYTE:    regs.command_byte    = i_cfg_data[BYTE_W-1:0];
                    CFG_READ_BIT:        regs.read_bit        = i_cfg_data[0];
                    CFG_WRITE_BIT:       regs.write_bit       = i_cfg_data[0];
                    CFG_DONE_EVENT_CODE: regs.done_event_code = i_cfg_data[EVENT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_commands.push_back(next_bus_commands(i_in_data));
            end
        end
        o_pending <= expected_commands.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C two-byte read sequencer testbench
// Drives bus events into the sequencer: a directed run through the idle
// faults, the full transaction with retries and restarts and the register
// extremes, then random transactions, truncated ones and loose events under
// several register settings, with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import i2ctbr_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int IDLE_PCT        = 7;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int TIMEOUT_CYCLES  = 400000;

    // Kinds outside the defined event set.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  quiet     = 1'b0;
    int                    fail_count;
    int                    pending;
    int                    events_sent = 0;

    i2c_two_byte_read_sequencer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sequencer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic t_in make_event(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] rx);
        return '{kind: kind, rx_byte: rx};
    endfunction

    // Leaves valid high on return so that back-to-back transfers need no gap.
    task automatic send_event(input t_in ev);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        events_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] addr, cmd, rd, wr, code);
        write_register(CFG_DEVICE_ADDRESS, addr);
        write_register(CFG_COMMAND_BYTE, cmd);
        write_register(CFG_READ_BIT, rd);
        write_register(CFG_WRITE_BIT, wr);
        write_register(CFG_DONE_EVENT_CODE, code);
        cfg_valid <= 1'b0;
    endtask

    // A well-formed read, optionally cut short after a number of events.
    task automatic random_transaction(input int cut);
        t_in seq[$];
        int  retries;
        seq.push_back(make_event(EV_START, BYTE_W'($urandom)));
        seq.push_back(make_event(EV_ACK, BYTE_W'($urandom)));
        seq.push_back(make_event(EV_ACK, BYTE_W'($urandom)));
        retries = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (retries) seq.push_back(make_event(EV_NACK, BYTE_W'($urandom)));
        seq.push_back(make_event(EV_ACK, BYTE_W'($urandom)));
        if ($urandom_range(4) == 0) seq.push_back(make_event(EV_ACK, BYTE_W'($urandom)));
        seq.push_back(make_event(EV_RX, BYTE_W'($urandom)));
        seq.push_back(make_event(EV_RX, BYTE_W'($urandom)));
        seq.push_back(make_event(EV_MSTOP, BYTE_W'($urandom)));
        foreach (seq[i]) begin
            if (cut < 0 || i < cut) send_event(seq[i]);
        end
    endtask

    task automatic loose_events(input int count);
        repeat (count) send_event(make_event(KIND_W'($urandom_range(KIND_SPARE_HI, 0)),
                                             BYTE_W'($urandom)));
    endtask

    initial begin
        int  start_count;
        int  pick;
        bit  paused;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Every event while idle is a fault, as are the spare kinds.
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_NACK, 8'h00));
        send_event(make_event(EV_RX, 8'hFF));
        send_event(make_event(EV_MSTOP, 8'h00));
        send_event(make_event(KIND_SPARE_LO, 8'h00));
        send_event(make_event(KIND_SPARE_HI, 8'hFF));
        // Full read with a retried repeated start and a harmless ack in the high byte.
        send_event(make_event(EV_START, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_NACK, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_RX, 8'hFF));
        send_event(make_event(EV_RX, 8'h00));
        send_event(make_event(EV_MSTOP, 8'h00));
        // Restart while busy, then events that the phase does not expect.
        send_event(make_event(EV_START, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_START, 8'h00));
        send_event(make_event(KIND_SPARE_HI, 8'h00));
        send_event(make_event(EV_MSTOP, 8'h00));
        send_event(make_event(EV_RX, 8'hA5));
        wait_idle();

        write_config(32'd127, 32'd255, 32'd0, 32'd1, 32'hFFFF_FFFF);
        send_event(make_event(EV_START, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_ACK, 8'h00));
        send_event(make_event(EV_RX, 8'h00));
        send_event(make_event(EV_RX, 8'hFF));
        send_event(make_event(EV_MSTOP, 8'h00));
        wait_idle();

        paused = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                write_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
            end else if (ph == 1) begin
                write_config(32'd127, 32'd255, 32'd1, 32'd1, 32'hFFFF_FFFF);
            end else begin
                // Upper bits beyond each register's width are junk on purpose.
                write_config($urandom, $urandom, $urandom, $urandom, $urandom);
            end
            quiet <= (ph == 2);
            start_count = events_sent;
            while (events_sent - start_count < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    random_transaction(-1);
                end else if (pick < 85) begin
                    random_transaction($urandom_range(1, 8));
                    loose_events($urandom_range(1, 3));
                end else begin
                    loose_events($urandom_range(1, 5));
                end
                // Hold the sender once until every outstanding result has come back.
                if (ph == 3 && !paused && events_sent - start_count >= ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
